### src/cst_pkg.sv
// shared types and codes for the call slot tracker
`timescale 1ns / 1ps

package cst_pkg;

	typedef enum logic [2:0] {
		OP_MAC     = 3'd0,
		OP_SETUP   = 3'd1,
		OP_CONNECT = 3'd2,
		OP_GRANT   = 3'd3,
		OP_RELEASE = 3'd4,
		OP_RESET   = 3'd5,
		OP_QUERY   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		CS_IDLE   = 2'd0,
		CS_SETUP  = 2'd1,
		CS_ACTIVE = 2'd2
	} call_state_t;

	typedef struct packed {
		call_state_t state;
		logic [15:0] call_number;
		logic [23:0] subscriber;
		logic [3:0]  prio;
		logic [1:0]  mode_flags;
		logic        ctrl_flag;
		logic        svc_flag;
		logic        encrypted_mark;
	} slot_entry_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  slot;
		logic [15:0] call_ident;
		logic [23:0] subscriber_id;
		logic [3:0]  call_priority;
		logic [1:0]  mac_enc_mode;
		logic        enc_control;
		logic        service_enc;
	} req_t;

	// running best candidate handed to the compare unit
	typedef struct packed {
		logic       have;
		logic       clear;
		logic [3:0] prio;
	} best_t;

endpackage

### src/cst_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface cst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [1:0]  slot;
	logic [15:0] call_ident;
	logic [23:0] subscriber_id;
	logic [3:0]  call_priority;
	logic [1:0]  mac_enc_mode;
	logic        enc_control;
	logic        service_enc;

	modport source (
		output valid, op, slot, call_ident, subscriber_id, call_priority,
			mac_enc_mode, enc_control, service_enc,
		input ready
	);
	modport sink (
		input valid, op, slot, call_ident, subscriber_id, call_priority,
			mac_enc_mode, enc_control, service_enc,
		output ready
	);
endinterface

interface cst_rsp_if;
	logic       valid;
	logic       ready;
	logic       pick_valid;
	logic [1:0] pick_slot;
	logic [1:0] slot_state;
	logic       slot_clear;

	modport source (
		output valid, pick_valid, pick_slot, slot_state, slot_clear,
		input ready
	);
	modport sink (
		input valid, pick_valid, pick_slot, slot_state, slot_clear,
		output ready
	);
endinterface

### src/cst_table.sv
// per-slot call state register file, one read and one write port
`timescale 1ns / 1ps

module cst_table #(
	parameter int NUM_SLOTS = 4,
	parameter int IDX_W = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      rd_addr,
	output cst_pkg::slot_entry_t  rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  cst_pkg::slot_entry_t  wr_data
);

	cst_pkg::slot_entry_t entry_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr_en) begin
			entry_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = entry_q[rd_addr];

endmodule

### src/cst_cmp.sv
// shared candidate compare unit used once per scanned slot
`timescale 1ns / 1ps

module cst_cmp (
	input  cst_pkg::slot_entry_t entry,
	input  logic                 mute,
	input  cst_pkg::best_t       best,
	output logic                 better
);

	logic eligible;
	logic clear;

	always_comb begin
		eligible = (entry.state != cst_pkg::CS_IDLE) && !(mute && entry.encrypted_mark);
		clear    = !entry.encrypted_mark;
		// clear beats encrypted, then higher priority; ties keep the earlier slot
		better   = eligible && (!best.have
			|| (clear && !best.clear)
			|| ((clear == best.clear) && (entry.prio > best.prio)));
	end

endmodule

### src/call_slot_tracker_selector_core.sv
// call slot tracker: event update then sequential slot selection scan
//
//   channel | dir | handshake          | payload
//   req     | in  | valid/ready        | op, slot, call_ident, subscriber_id, call_priority,
//           |     |                    | mac_enc_mode, enc_control, service_enc
//   rsp     | out | valid/ready        | pick_valid, pick_slot, slot_state, slot_clear
//   cfg     | in  | cfg_we / cfg_wdata | mute bit for encrypted slots
//
// once a request is accepted, ST_UPDATE updates the addressed slot, ST_SCAN makes one
// compare per slot through the shared compare unit, which reads the slot table through
// its single read port, and ST_DONE loads the response register.
// the next request is taken in the cycle after the load.
// a held response stalls only the final load; the next request waits until then.
// reset clears every slot to idle, the mute bit and the response register at once.
`timescale 1ns / 1ps

module call_slot_tracker_selector_core #(
	parameter int NUM_SLOTS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	cst_req_if.sink       req,
	cst_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SW    = (IDX_W > 2) ? IDX_W : 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DONE
	} seq_state_t;

	seq_state_t           state_q;
	cst_pkg::req_t        req_q;
	logic                 ok_q;
	logic                 mute_q;
	logic [IDX_W-1:0]     scan_idx_q;
	cst_pkg::best_t       best_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [1:0]           addr_state_q;
	logic                 addr_clear_q;
	logic                 rsp_valid_q;
	logic                 rsp_pick_valid_q;
	logic [1:0]           rsp_pick_slot_q;
	logic [1:0]           rsp_slot_state_q;
	logic                 rsp_slot_clear_q;

	logic [SW-1:0]        slot_ext;
	logic [IDX_W-1:0]     slot_idx;
	logic [IDX_W-1:0]     rd_addr;
	cst_pkg::slot_entry_t rd_entry;
	cst_pkg::slot_entry_t new_entry;
	logic                 wr_en;
	logic                 better;
	logic                 req_ok;
	logic                 out_free;
	logic [SW-1:0]        best_slot_ext;

	assign req_ok   = (32'(req.slot) < NUM_SLOTS);
	assign slot_ext = SW'(req_q.slot);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign rd_addr  = (state_q == ST_SCAN) ? scan_idx_q : slot_idx;
	assign wr_en    = (state_q == ST_UPDATE) && ok_q;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign best_slot_ext = SW'(best_slot_q);

	cst_table #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (slot_idx),
		.wr_data (new_entry)
	);

	cst_cmp u_cmp (
		.entry  (rd_entry),
		.mute   (mute_q),
		.best   (best_q),
		.better (better)
	);

	// event effect on the addressed slot
	always_comb begin
		new_entry = rd_entry;
		case (cst_pkg::op_t'(req_q.op))
			cst_pkg::OP_MAC: begin
				new_entry.mode_flags = req_q.mac_enc_mode;
				if (rd_entry.state == cst_pkg::CS_IDLE) begin
					new_entry.state = cst_pkg::CS_ACTIVE;
				end
			end
			cst_pkg::OP_SETUP: begin
				new_entry.state       = cst_pkg::CS_SETUP;
				new_entry.call_number = req_q.call_ident;
				new_entry.subscriber  = req_q.subscriber_id;
				new_entry.prio        = req_q.call_priority;
				new_entry.ctrl_flag   = req_q.enc_control;
				new_entry.svc_flag    = req_q.service_enc;
			end
			cst_pkg::OP_CONNECT, cst_pkg::OP_GRANT: begin
				if (rd_entry.state == cst_pkg::CS_IDLE) begin
					new_entry.call_number = req_q.call_ident;
					new_entry.prio        = '0;
				end
				new_entry.state     = cst_pkg::CS_ACTIVE;
				new_entry.ctrl_flag = req_q.enc_control;
				if (cst_pkg::op_t'(req_q.op) == cst_pkg::OP_CONNECT) begin
					new_entry.svc_flag = req_q.service_enc;
				end
			end
			cst_pkg::OP_RELEASE: begin
				// zero id releases whatever call is on the slot
				if (req_q.call_ident == '0 || rd_entry.call_number == req_q.call_ident) begin
					new_entry = '0;
				end
			end
			cst_pkg::OP_RESET: begin
				new_entry = '0;
			end
			default: begin
			end
		endcase
		new_entry.encrypted_mark = (new_entry.mode_flags != '0) || new_entry.ctrl_flag
			|| new_entry.svc_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			req_q            <= '0;
			ok_q             <= 1'b0;
			mute_q           <= 1'b0;
			rsp_valid_q      <= 1'b0;
			rsp_pick_valid_q <= 1'b0;
			rsp_pick_slot_q  <= '0;
			rsp_slot_state_q <= '0;
			rsp_slot_clear_q <= 1'b0;
			addr_state_q     <= '0;
			addr_clear_q     <= 1'b0;
			best_q           <= '0;
			scan_idx_q       <= '0;
			best_slot_q      <= '0;
		end else begin
			if (cfg_we) begin
				mute_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q   <= cst_pkg::req_t'({req.op, req.slot, req.call_ident,
							req.subscriber_id, req.call_priority, req.mac_enc_mode,
							req.enc_control, req.service_enc});
						ok_q    <= req_ok;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (ok_q) begin
						addr_state_q <= new_entry.state;
						addr_clear_q <= !new_entry.encrypted_mark;
					end else begin
						addr_state_q <= cst_pkg::CS_IDLE;
						addr_clear_q <= 1'b1;
					end
					scan_idx_q  <= '0;
					best_q      <= '0;
					best_slot_q <= '0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (better) begin
						best_q.have  <= 1'b1;
						best_q.clear <= !rd_entry.encrypted_mark;
						best_q.prio  <= rd_entry.prio;
						best_slot_q  <= scan_idx_q;
					end
					if (scan_idx_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_pick_valid_q <= best_q.have;
						rsp_pick_slot_q  <= best_q.have ? best_slot_ext[1:0] : 2'd0;
						rsp_slot_state_q <= addr_state_q;
						rsp_slot_clear_q <= addr_clear_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.pick_valid = rsp_pick_valid_q;
	assign rsp.pick_slot  = rsp_pick_slot_q;
	assign rsp.slot_state = rsp_slot_state_q;
	assign rsp.slot_clear = rsp_slot_clear_q;

endmodule

### src/cst_checker.sv
// port-level checks for the call slot tracker, bound to the top level
`timescale 1ns / 1ps

module cst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       pick_valid,
	input logic [1:0] pick_slot,
	input logic [1:0] slot_state,
	input logic       slot_clear
);

	// a held response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after accepting a request");

	a_no_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !pick_valid |-> pick_slot == 2'd0)
		else $error("pick slot nonzero without a pick");

	// an idle slot never carries encryption flags
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && slot_state == 2'd0 |-> slot_clear)
		else $error("idle slot reported encrypted");

endmodule

bind call_slot_tracker_selector_core cst_checker u_cst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.pick_valid (rsp.pick_valid),
	.pick_slot  (rsp.pick_slot),
	.slot_state (rsp.slot_state),
	.slot_clear (rsp.slot_clear)
);
